// File: hdl/ymr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ymr_pkg
// Shared types, protocol bytes and the CRC helper function of the packet receiver.
// ----------------------------------------------------------------------------
package ymr_pkg;

   localparam logic [7:0] B_SOH = 8'h01;
   localparam logic [7:0] B_STX = 8'h02;
   localparam logic [7:0] B_EOT = 8'h04;
   localparam logic [7:0] B_ACK = 8'h06;
   localparam logic [7:0] B_NAK = 8'h15;
   localparam logic [7:0] B_CAN = 8'h18;
   localparam logic [7:0] B_C   = 8'h43;

   localparam logic [1:0] CMD_BYTE    = 2'd0;
   localparam logic [1:0] CMD_TIMEOUT = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;
   localparam logic [1:0] CMD_SPARE   = 2'd3;

   localparam logic [1:0] REG_CHECK_SEL  = 2'd0;
   localparam logic [1:0] REG_SIZE_LIMIT = 2'd1;
   localparam logic [1:0] REG_INIT_RETRY = 2'd2;
   localparam logic [1:0] REG_DATA_RETRY = 2'd3;

   localparam logic [3:0] V_NONE      = 4'd0;
   localparam logic [3:0] V_HEADER    = 4'd1;
   localparam logic [3:0] V_DATA      = 4'd2;
   localparam logic [3:0] V_DUP       = 4'd3;
   localparam logic [3:0] V_BAD       = 4'd4;
   localparam logic [3:0] V_EOT       = 4'd5;
   localparam logic [3:0] V_CANCEL    = 4'd6;
   localparam logic [3:0] V_DONE      = 4'd7;
   localparam logic [3:0] V_TOO_LARGE = 4'd8;
   localparam logic [3:0] V_ERRORS    = 4'd9;
   localparam logic [3:0] V_RESYNC    = 4'd10;
   localparam logic [3:0] V_TIMEOUT   = 4'd11;

   localparam int SHORT_PAYLOAD = 128;

   // Frame phase, one-hot.
   typedef enum logic [2:0] {
      FP_OFF  = 3'b001,
      FP_HUNT = 3'b010,
      FP_BODY = 3'b100
   } frame_type;

   // Protocol state, one-hot.
   typedef enum logic [3:0] {
      PS_IDLE = 4'b0001,
      PS_HDR  = 4'b0010,
      PS_DAT  = 4'b0100,
      PS_EOT  = 4'b1000
   } proto_type;

   // Header size parser phase, one-hot.
   typedef enum logic [3:0] {
      HP_NAME   = 4'b0001,
      HP_ZEROS  = 4'b0010,
      HP_DIGITS = 4'b0100,
      HP_DONE   = 4'b1000
   } hparse_type;

   // One decoded event from the input register.
   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] rx_byte;
   } event_type;

   // One result item.
   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        data_valid;
      logic [7:0]  data_byte;
      logic [9:0]  data_index;
      logic        in_file;
      logic [3:0]  verdict;
      logic [31:0] file_size;
   } result_type;

   // Configuration register values.
   typedef struct packed {
      logic        use_crc;
      logic [31:0] size_limit;
      logic [5:0]  initial_retries;
      logic [5:0]  data_retries;
   } cfg_type;

   // One CRC-16/XMODEM byte update, eight bit steps on a 16-bit value.
   function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] v;
      v = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         v = v[15] ? ((v << 1) ^ 16'h1021) : (v << 1);
      end
      return v;
   endfunction

endpackage

// File: hdl/ymodem_packet_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ymodem_packet_receiver_unit
// YMODEM/XMODEM receiver that turns sender events into handshake and data.
// ----------------------------------------------------------------------------
// Each req_ transaction carries one event: a received byte, a timeout or a
// restart. Each event yields exactly one rsp_ transaction with the handshake
// byte to send, an optional payload byte with its index and in-file flag, a
// packet verdict and, with a header verdict, the parsed file size.
// The event is captured in an input register and evaluated in one pass of
// logic into the result register, which drives rsp_. While rsp_tready is
// high, one event per cycle is sustained; the input register refills whenever
// the result register is free or being drained, so a stalled rsp_ side holds
// at most one result and one queued event before req_tready drops. Reset
// loads the default registers and leaves the receiver inactive until a restart
// event. The csr_ port writes one register per cycle; the user must use it only
// while no event is in flight, as the block does not enforce this.
// ----------------------------------------------------------------------------
module ymodem_packet_receiver_unit
   import ymr_pkg::*;
#(
   parameter int LONG_PAYLOAD = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cmd[1:0], rx_byte[9:2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // tx_valid, tx_byte, data_valid, data_byte,
                                    // data_index, in_file, verdict, file_size
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type    cfg;
   event_type  ev_ff;
   logic       ev_vld_ff;
   result_type res;
   result_type out_ff;
   logic       out_vld_ff;
   logic       out_free;
   logic       step;

   assign out_free = !out_vld_ff || rsp_tready;
   assign step = ev_vld_ff && out_free;
   assign req_tready = !ev_vld_ff || out_free;

   ymr_cfg_regs u_cfg (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata, .cfg
   );

   ymr_core #(.LONG_PAYLOAD(LONG_PAYLOAD)) u_core (
      .clock, .reset, .ev_valid(step), .ev(ev_ff), .cfg, .res
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ev_vld_ff <= 1'b0;
      end else if (req_tready) begin
         ev_vld_ff <= req_tvalid;
      end
      if (req_tready) begin
         ev_ff <= '{cmd: req_tdata[1:0], rx_byte: req_tdata[9:2]};
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_free) begin
         out_vld_ff <= step;
      end
      if (step) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = {7'b0, out_ff.file_size, out_ff.verdict, out_ff.in_file,
                       out_ff.data_index, out_ff.data_byte, out_ff.data_valid,
                       out_ff.tx_byte, out_ff.tx_valid};

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_step_free: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_tvalid)
      else $error("evaluated event produced no result");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      ev_vld_ff && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("accepted an event with no room");
`endif

endmodule

// File: hdl/ymr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ymr_cfg_regs
// Configuration register bank written through a plain write port.
// ----------------------------------------------------------------------------
module ymr_cfg_regs
   import ymr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Select the register addressed by the write.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_CHECK_SEL:  cfg_in.use_crc         = csr_wdata[0];
            REG_SIZE_LIMIT: cfg_in.size_limit      = csr_wdata;
            REG_INIT_RETRY: cfg_in.initial_retries = csr_wdata[5:0];
            REG_DATA_RETRY: cfg_in.data_retries    = csr_wdata[5:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{use_crc: 1'b1, size_limit: 32'd1048576,
                     initial_retries: 6'd30, data_retries: 6'd2};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/ymr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ymr_core
// Protocol state and the single-pass next-state logic for one event.
// ----------------------------------------------------------------------------
module ymr_core
   import ymr_pkg::*;
#(
   parameter int LONG_PAYLOAD = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       ev_valid,
   input  event_type  ev,
   input  cfg_type    cfg,
   output result_type res
);

   localparam int PW = 11;

   frame_type   frame_ff, frame_in;
   proto_type   proto_ff, proto_in;
   hparse_type  hp_ff, hp_in;
   logic [7:0]  sync_ff, sync_in;
   logic [31:0] pnum_ff, pnum_in;
   logic [5:0]  retry_ff, retry_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] limit_ff, limit_in;
   logic        fb_ff, fb_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic        long_ff, long_in;
   logic [7:0]  seq_ff, seq_in;
   logic [7:0]  cpl_ff, cpl_in;
   logic [15:0] run_ff, run_in;
   logic [15:0] rcv_ff, rcv_in;
   logic [31:0] psize_ff, psize_in;

   logic [PW-1:0] len;
   logic [PW-1:0] idx;
   logic [PW-1:0] k;
   logic [15:0]   rcv_final;
   logic          ok_check;
   logic          again;
   logic          is_digit;
   logic [3:0]    digit;
   logic [31:0]   room;
   logic [32:0]   pos_sum;
   logic [7:0]    b;
   logic          bad;

   assign b = ev.rx_byte;
   assign len = long_ff ? PW'(LONG_PAYLOAD) : PW'(SHORT_PAYLOAD);
   assign idx = pos_ff - PW'(2);
   assign k = pos_ff - PW'(2) - len;
   assign is_digit = (b >= 8'h30) && (b <= 8'h39);
   assign digit = 4'(b - 8'h30);
   assign room = limit_ff - count_ff;
   assign pos_sum = {1'b0, count_ff} + 33'(idx);

   // Next state and result for one event.
   always_comb begin
      frame_in = frame_ff; proto_in = proto_ff; hp_in = hp_ff;
      sync_in = sync_ff; pnum_in = pnum_ff; retry_in = retry_ff;
      count_in = count_ff; limit_in = limit_ff; fb_in = fb_ff;
      pos_in = pos_ff; long_in = long_ff; seq_in = seq_ff; cpl_in = cpl_ff;
      run_in = run_ff; rcv_in = rcv_ff; psize_in = psize_ff;
      res = '0;
      again = 1'b0;
      bad = 1'b0;
      rcv_final = cfg.use_crc ? {rcv_ff[15:8], b} : {8'h00, b};
      ok_check = cfg.use_crc ? (rcv_final == run_ff) : (rcv_final[7:0] == run_ff[7:0]);
      if (ev_valid) begin
         if (ev.cmd == CMD_RESTART) begin
            pnum_in = '0;
            sync_in = cfg.use_crc ? B_C : B_NAK;
            limit_in = cfg.size_limit;
            retry_in = cfg.initial_retries;
            count_in = '0;
            proto_in = PS_IDLE;
            fb_in = 1'b0;
            pos_in = '0;
            frame_in = FP_HUNT;
            res.tx_valid = 1'b1;
            res.tx_byte = sync_in;
         end else if (frame_ff != FP_OFF && ev.cmd == CMD_TIMEOUT) begin
            if (proto_ff == PS_EOT) begin
               sync_in = B_CAN; frame_in = FP_OFF; res.verdict = V_DONE;
            end else if (proto_ff == PS_HDR) begin
               sync_in = cfg.use_crc ? B_C : B_NAK;
               frame_in = FP_HUNT;
               res.tx_valid = 1'b1; res.tx_byte = sync_in; res.verdict = V_RESYNC;
            end else if (count_ff == limit_ff && !fb_ff) begin
               sync_in = B_CAN; frame_in = FP_OFF;
               res.tx_valid = 1'b1; res.tx_byte = B_CAN; res.verdict = V_TOO_LARGE;
            end else begin
               bad = 1'b1; res.verdict = V_TIMEOUT;
            end
         end else if (frame_ff == FP_HUNT && ev.cmd == CMD_BYTE) begin
            if (b == B_STX || b == B_SOH) begin
               long_in = (b == B_STX); frame_in = FP_BODY; pos_in = '0;
               run_in = '0; rcv_in = '0; hp_in = HP_NAME; psize_in = '0;
            end else if (b == B_CAN) begin
               sync_in = B_ACK; frame_in = FP_OFF; res.verdict = V_CANCEL;
            end else if (b == B_EOT) begin
               sync_in = B_ACK; proto_in = PS_EOT;
               res.tx_valid = 1'b1; res.tx_byte = B_ACK; res.verdict = V_EOT;
            end
         end else if (frame_ff == FP_BODY && ev.cmd == CMD_BYTE) begin
            pos_in = pos_ff + PW'(1);
            if (pos_ff == PW'(0)) begin
               seq_in = b;
            end else if (pos_ff == PW'(1)) begin
               cpl_in = b;
            end else if (pos_ff < PW'(2) + len) begin
               run_in = cfg.use_crc ? crc_step(run_ff, b) : {8'h00, run_ff[7:0] + b};
               case (hp_ff)
                  HP_NAME: if (b == 8'h00) hp_in = (idx == PW'(0)) ? HP_DONE : HP_ZEROS;
                  HP_ZEROS: begin
                     if (b != 8'h00) begin
                        if (is_digit) begin
                           psize_in = 32'(digit); hp_in = HP_DIGITS;
                        end else begin
                           hp_in = HP_DONE;
                        end
                     end
                  end
                  HP_DIGITS: begin
                     if (is_digit) psize_in = (psize_ff << 3) + (psize_ff << 1) + 32'(digit);
                     else hp_in = HP_DONE;
                  end
                  default: hp_in = hp_ff;
               endcase
               res.data_valid = 1'b1;
               res.data_byte = b;
               res.data_index = idx[9:0];
               res.in_file = pos_sum < {1'b0, limit_ff};
            end else if (cfg.use_crc && k == PW'(0)) begin
               rcv_in = {b, 8'h00};
            end else begin
               rcv_in = rcv_final;
               // Packet complete: sequence, check and numbering.
               if (seq_ff != ~cpl_ff || !ok_check) begin
                  bad = 1'b1; res.verdict = V_BAD;
               end else if (seq_ff == 8'(pnum_ff - 32'd1) &&
                            !(seq_ff == 8'h00 && pnum_ff == 32'd1 && !fb_ff)) begin
                  frame_in = FP_HUNT;
                  res.tx_valid = 1'b1; res.tx_byte = sync_ff; res.verdict = V_DUP;
               end else begin
                  logic [31:0] pn;
                  logic        fb;
                  pn = pnum_ff; fb = fb_ff;
                  if (seq_ff == 8'h00 && pnum_ff == 32'd1 && !fb_ff) begin
                     pn = '0; again = 1'b1;
                  end
                  if (seq_ff != pn[7:0]) begin
                     if (pn == '0 && seq_ff == 8'h01) begin
                        pn = 32'd1; fb = 1'b1;
                     end else begin
                        bad = 1'b1; res.verdict = V_BAD;
                     end
                  end
                  if (!bad) begin
                     fb_in = fb;
                     sync_in = B_ACK; frame_in = FP_HUNT;
                     res.tx_valid = 1'b1; res.tx_byte = B_ACK;
                     pnum_in = pn + 32'd1;
                     if (pn == '0 && !fb && (proto_ff == PS_IDLE || again)) begin
                        res.file_size = (hp_ff == HP_DIGITS || hp_ff == HP_DONE) ?
                                        psize_ff : 32'd0;
                        if (res.file_size != '0) begin
                           proto_in = PS_HDR; limit_in = res.file_size;
                        end else begin
                           proto_in = PS_EOT;
                        end
                        res.verdict = V_HEADER;
                     end else begin
                        retry_in = cfg.data_retries;
                        proto_in = PS_DAT;
                        if (count_ff < limit_ff)
                           count_in = count_ff + ((32'(len) < room) ? 32'(len) : room);
                        res.verdict = V_DATA;
                     end
                  end
               end
            end
         end
         // Spend a retry, or give up when the budget is gone.
         if (bad) begin
            res.tx_valid = 1'b1;
            if (retry_ff <= 6'd1) begin
               retry_in = '0; sync_in = B_CAN; frame_in = FP_OFF;
               res.tx_byte = B_CAN; res.verdict = V_ERRORS;
            end else begin
               retry_in = retry_ff - 6'd1; frame_in = FP_HUNT;
               res.tx_byte = sync_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= FP_OFF; proto_ff <= PS_IDLE; hp_ff <= HP_NAME;
         sync_ff <= B_C; pnum_ff <= '0; retry_ff <= 6'd30;
         count_ff <= '0; limit_ff <= 32'd1048576; fb_ff <= 1'b0;
         pos_ff <= '0; long_ff <= 1'b0; seq_ff <= '0; cpl_ff <= '0;
         run_ff <= '0; rcv_ff <= '0; psize_ff <= '0;
      end else begin
         frame_ff <= frame_in; proto_ff <= proto_in; hp_ff <= hp_in;
         sync_ff <= sync_in; pnum_ff <= pnum_in; retry_ff <= retry_in;
         count_ff <= count_in; limit_ff <= limit_in; fb_ff <= fb_in;
         pos_ff <= pos_in; long_ff <= long_in; seq_ff <= seq_in; cpl_ff <= cpl_in;
         run_ff <= run_in; rcv_ff <= rcv_in; psize_ff <= psize_in;
      end
   end

`ifndef SYNTHESIS
   a_frame_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(frame_ff))
      else $error("frame phase not one-hot");
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      ev_valid && res.verdict == V_DATA |=> count_ff <= limit_ff || $stable(count_ff))
      else $error("byte count passed the file limit");
   a_restart_hunt: assert property (@(posedge clock) disable iff (reset)
      ev_valid && ev.cmd == CMD_RESTART |=> frame_ff == FP_HUNT && count_ff == '0)
      else $error("restart did not start hunting");
`endif

endmodule
